### sv/slot_allocator_name_table_assert.svh
// Assertion macros for the slot allocator RTL.
`ifndef SLOT_ALLOCATOR_NAME_TABLE_ASSERT_SVH
`define SLOT_ALLOCATOR_NAME_TABLE_ASSERT_SVH

`ifndef SYNTH

// Checked only while the block is out of reset.
`define SANTBL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define SANTBL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SANTBL_ASSERT(lbl, clk, rstn, prop, msg)
`define SANTBL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### sv/santbl_pkg.sv
package santbl_pkg;

    localparam int DEF_SLOT_COUNT = 24;
    localparam int DEF_BANK_BASE  = 2;

    localparam int ID_W     = 8;
    localparam int NAME_W   = 56;
    localparam int ENTRY_W  = 16;
    localparam int STATUS_W = 8;

    localparam logic [ID_W-1:0]     NONE_SLOT    = 8'hFF;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 8'h00;
    localparam logic [STATUS_W-1:0] STATUS_RUN   = 8'h01;

    typedef enum logic [2:0] {
        ACT_REGISTER   = 3'd0,
        ACT_UNREGISTER = 3'd1,
        ACT_SET_STATUS = 3'd2,
        ACT_SET_CUR    = 3'd3,
        ACT_QUERY      = 3'd4,
        ACT_FIND       = 3'd5
    } t_action;

    // Request as broadcast to every cell of the row.
    typedef struct packed {
        t_action               action;
        logic [ID_W-1:0]       slot_id;
        logic [NAME_W-1:0]     name;
        logic [ENTRY_W-1:0]    entry;
        logic [STATUS_W-1:0]   new_status;
    } t_req;

    // Readback of the addressed slot, collected along the row.
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [NAME_W-1:0]     name;
        logic [ENTRY_W-1:0]    entry;
    } t_rd;

    // A name ends at its first zero byte; every byte after it reads as zero.
    function automatic logic [NAME_W-1:0] name_norm(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] kept;
        logic              live;
        kept = '0;
        live = 1'b1;
        for (int b = 0; b < NAME_W / 8; b++) begin
            if (raw[8*b +: 8] == 8'h00) begin
                live = 1'b0;
            end
            if (live) begin
                kept[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return kept;
    endfunction

endpackage

### sv/santbl_cell.sv
module santbl_cell
    import santbl_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_req                i_req,
    input  logic                i_commit,
    input  logic                i_prior_hit,
    input  logic [ID_W-1:0]     i_found,
    input  t_rd                 i_rd,
    output logic                o_prior_hit,
    output logic [ID_W-1:0]     o_found,
    output t_rd                 o_rd
);

    logic [STATUS_W-1:0] r_status;
    logic [NAME_W-1:0]   r_name;
    logic [ENTRY_W-1:0]  r_entry;

    logic w_sel;
    logic w_used;
    logic w_hit;
    logic w_first;

    localparam logic [ID_W-1:0] MY_ID = ID_W'(CELL_INDEX);

    assign w_sel  = (i_req.slot_id == MY_ID);
    assign w_used = (r_status != STATUS_EMPTY);

    // A cell hits on a free slot for register and on a used slot with a
    // matching name for find; the lowest hitting cell wins the priority chain.
    assign w_hit = ((i_req.action == ACT_REGISTER) && !w_used) ||
                   ((i_req.action == ACT_FIND) && w_used && (r_name == i_req.name));
    assign w_first     = w_hit && !i_prior_hit;
    assign o_prior_hit = i_prior_hit | w_hit;
    assign o_found     = i_found | (w_first ? MY_ID : '0);

    assign o_rd.status = i_rd.status | (w_sel ? r_status : '0);
    assign o_rd.name   = i_rd.name   | (w_sel ? r_name   : '0);
    assign o_rd.entry  = i_rd.entry  | (w_sel ? r_entry  : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= STATUS_EMPTY;
            r_name   <= '0;
            r_entry  <= '0;
        end else if (i_commit) begin
            case (i_req.action)
                ACT_REGISTER: begin
                    if (w_first) begin
                        r_status <= STATUS_RUN;
                        r_name   <= i_req.name;
                        r_entry  <= i_req.entry;
                    end
                end
                ACT_UNREGISTER: begin
                    if (w_sel && w_used) begin
                        r_status <= STATUS_EMPTY;
                        r_name   <= '0;
                        r_entry  <= '0;
                    end
                end
                ACT_SET_STATUS: begin
                    if (w_sel) begin
                        r_status <= i_req.new_status;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### sv/slot_allocator_name_table.sv
// Slot allocator with name table. Each slot lives in one cell of a row; a
// request is registered on acceptance and executed in S_EXEC, where it
// reaches every cell at once and three chains run down the row: the
// first-hit priority chain for register and find by name, the slot index
// of the winner, and the readback of the addressed slot. The state update
// and the result register load on the edge that ends execution, and a new
// request is taken only once the previous one has executed. A result
// waiting in the output register does not block acceptance; execution
// stalls only while the previous result has not been taken. All slots are
// free after reset, with no clearing pass.
module slot_allocator_name_table
    import santbl_pkg::*;
#(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT,
    parameter int BANK_BASE  = DEF_BANK_BASE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_action,
    input  logic [ID_W-1:0]     i_slot_id,
    input  logic [NAME_W-1:0]   i_name_chars,
    input  logic [ENTRY_W-1:0]  i_entry_address,
    input  logic [STATUS_W-1:0] i_new_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [ID_W-1:0]     o_found_slot,
    output logic [STATUS_W-1:0] o_slot_status,
    output logic [7:0]          o_slot_bank,
    output logic [NAME_W-1:0]   o_slot_name,
    output logic [ENTRY_W-1:0]  o_slot_entry,
    output logic                o_slot_in_use,
    output logic [7:0]          o_in_use_count,
    output logic [ID_W-1:0]     o_current_slot
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state              r_state;
    t_req                r_req;
    logic [7:0]          r_count;
    logic [ID_W-1:0]     r_current;
    logic                r_out_valid;

    logic [ID_W-1:0]     n_found;
    logic [STATUS_W-1:0] n_q_status;
    logic [7:0]          n_q_bank;
    logic [NAME_W-1:0]   n_q_name;
    logic [ENTRY_W-1:0]  n_q_entry;
    logic                n_q_used;
    logic [7:0]          n_count;
    logic [ID_W-1:0]     n_current;

    logic                w_commit;
    logic                w_in_range;
    logic                w_rd_used;

    logic                w_prior [SLOT_COUNT+1];
    logic [ID_W-1:0]     w_found [SLOT_COUNT+1];
    t_rd                 w_rd    [SLOT_COUNT+1];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_commit    = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    assign w_prior[0] = 1'b0;
    assign w_found[0] = '0;
    assign w_rd[0]    = '0;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        santbl_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_req       (r_req),
            .i_commit    (w_commit),
            .i_prior_hit (w_prior[g]),
            .i_found     (w_found[g]),
            .i_rd        (w_rd[g]),
            .o_prior_hit (w_prior[g+1]),
            .o_found     (w_found[g+1]),
            .o_rd        (w_rd[g+1])
        );
    end

    // The readback chain is all zero when the slot id is out of range.
    assign w_in_range = (r_req.slot_id < ID_W'(SLOT_COUNT));
    assign w_rd_used  = (w_rd[SLOT_COUNT].status != STATUS_EMPTY);

    always_comb begin
        n_found    = NONE_SLOT;
        n_q_status = '0;
        n_q_bank   = '0;
        n_q_name   = '0;
        n_q_entry  = '0;
        n_q_used   = 1'b0;
        n_count    = r_count;
        n_current  = r_current;
        case (r_req.action)
            ACT_REGISTER: begin
                if (w_prior[SLOT_COUNT]) begin
                    n_found   = w_found[SLOT_COUNT];
                    n_count   = r_count + 8'd1;
                    n_current = w_found[SLOT_COUNT];
                end
            end
            ACT_UNREGISTER: begin
                if (w_rd_used) begin
                    if (r_count != 8'd0) begin
                        n_count = r_count - 8'd1;
                    end
                    if (r_current == r_req.slot_id) begin
                        n_current = NONE_SLOT;
                    end
                end
            end
            ACT_SET_CUR: begin
                n_current = w_rd_used ? r_req.slot_id : NONE_SLOT;
            end
            ACT_QUERY: begin
                if (w_in_range) begin
                    n_q_status = w_rd[SLOT_COUNT].status;
                    n_q_bank   = 8'(BANK_BASE) + r_req.slot_id;
                    n_q_entry  = w_rd[SLOT_COUNT].entry;
                    n_q_used   = w_rd_used;
                    n_q_name   = w_rd_used ? w_rd[SLOT_COUNT].name : '0;
                end
            end
            ACT_FIND: begin
                if (w_prior[SLOT_COUNT]) begin
                    n_found = w_found[SLOT_COUNT];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_current   <= NONE_SLOT;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req.action     <= t_action'(i_action);
                        r_req.slot_id    <= i_slot_id;
                        r_req.name       <= name_norm(i_name_chars);
                        r_req.entry      <= i_entry_address;
                        r_req.new_status <= i_new_status;
                        r_state          <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_commit) begin
                        r_count        <= n_count;
                        r_current      <= n_current;
                        o_found_slot   <= n_found;
                        o_slot_status  <= n_q_status;
                        o_slot_bank    <= n_q_bank;
                        o_slot_name    <= n_q_name;
                        o_slot_entry   <= n_q_entry;
                        o_slot_in_use  <= n_q_used;
                        o_in_use_count <= n_count;
                        o_current_slot <= n_current;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "slot_allocator_name_table_assert.svh"

    `SANTBL_ASSERT(a_current_valid, i_clk, i_rst_n, (r_current == NONE_SLOT) || (r_current < ID_W'(SLOT_COUNT)), "current slot outside the table")
    `SANTBL_ASSERT(a_found_valid, i_clk, i_rst_n, o_out_valid |-> ((o_found_slot == NONE_SLOT) || (o_found_slot < ID_W'(SLOT_COUNT))), "found slot outside the table")
    `SANTBL_ASSERT(a_accept_exec, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_EXEC), "accepted request did not start executing")
    `SANTBL_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> ((r_current == NONE_SLOT) && (r_count == 8'd0) && !o_out_valid), "reset did not clear control state")

endmodule

### bench/tb_slot_allocator_name_table.sv
`timescale 1ns / 100ps

module tb_slot_allocator_name_table
    import santbl_pkg::*;
;

    localparam int TABLE_SLOTS = DEF_SLOT_COUNT;
    localparam int TABLE_BANK  = DEF_BANK_BASE;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 40;
    localparam int POOL_NAMES  = 8;

    // The action field is three bits wide; these two codes have no operation.
    localparam logic [2:0] ACT_RSVD_LO = 3'd6;
    localparam logic [2:0] ACT_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [2:0]          action;
        logic [ID_W-1:0]     slot_id;
        logic [NAME_W-1:0]   name;
        logic [ENTRY_W-1:0]  entry;
        logic [STATUS_W-1:0] status;
    } t_slot_req;

    typedef struct packed {
        logic [ID_W-1:0]     found;
        logic [STATUS_W-1:0] status;
        logic [7:0]          bank;
        logic [NAME_W-1:0]   name;
        logic [ENTRY_W-1:0]  entry;
        logic                in_use;
        logic [7:0]          count;
        logic [ID_W-1:0]     current;
    } t_slot_result;

    typedef struct packed {
        t_slot_req    req;
        logic         typed;
        t_slot_result res;
    } t_directed_row;

    localparam t_slot_result NO_RESULT = '0;
    localparam t_slot_result EMPTY_TABLE_VIEW =
        '{NONE_SLOT, 8'h00, 8'h00, 56'h0, 16'h0, 1'b0, 8'd0, NONE_SLOT};

    localparam int DIRECTED_ROWS = 26;

    // Rows with typed results are checked against the hand-written value; the
    // rest go through the predictor like the random requests.
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{'{ACT_QUERY, 8'd0, 56'h0, 16'h0, 8'h00}, 1'b1,
          '{NONE_SLOT, 8'h00, 8'd2, 56'h0, 16'h0, 1'b0, 8'd0, NONE_SLOT}},
        '{'{ACT_QUERY, 8'd255, 56'h0, 16'h0, 8'h00}, 1'b1, EMPTY_TABLE_VIEW},
        '{'{ACT_FIND, 8'd0, 56'h0, 16'h0, 8'h00}, 1'b1, EMPTY_TABLE_VIEW},
        '{'{ACT_UNREGISTER, 8'd0, 56'h0, 16'h0, 8'h00}, 1'b1, EMPTY_TABLE_VIEW},
        '{'{ACT_SET_CUR, 8'd0, 56'h0, 16'h0, 8'h00}, 1'b1, EMPTY_TABLE_VIEW},
        '{'{ACT_SET_STATUS, 8'd5, 56'h0, 16'h0, 8'h02}, 1'b1, EMPTY_TABLE_VIEW},
        '{'{ACT_UNREGISTER, 8'd5, 56'h0, 16'h0, 8'h00}, 1'b1, EMPTY_TABLE_VIEW},
        '{'{ACT_QUERY, 8'd5, 56'h0, 16'h0, 8'h00}, 1'b1,
          '{NONE_SLOT, 8'h00, 8'd7, 56'h0, 16'h0, 1'b0, 8'd0, NONE_SLOT}},
        '{'{ACT_REGISTER, 8'd0, 56'h41, 16'hFFFF, 8'h00}, 1'b1,
          '{8'd0, 8'h00, 8'h00, 56'h0, 16'h0, 1'b0, 8'd1, 8'd0}},
        '{'{ACT_REGISTER, 8'd255, 56'hFF_FFFF_FFFF_FFFF, 16'h0000, 8'hFF}, 1'b1,
          '{8'd1, 8'h00, 8'h00, 56'h0, 16'h0, 1'b0, 8'd2, 8'd1}},
        '{'{ACT_REGISTER, 8'd0, 56'h11_2233_0044_5566, 16'h1234, 8'h00}, 1'b0, NO_RESULT},
        '{'{ACT_REGISTER, 8'd0, 56'h0, 16'h8000, 8'h00}, 1'b0, NO_RESULT},
        '{'{ACT_QUERY, 8'd2, 56'h0, 16'h0, 8'h00}, 1'b0, NO_RESULT},
        '{'{ACT_QUERY, 8'd1, 56'h0, 16'h0, 8'h00}, 1'b0, NO_RESULT},
        '{'{ACT_FIND, 8'd0, 56'h99_0000_0044_5566, 16'h0, 8'h00}, 1'b0, NO_RESULT},
        '{'{ACT_FIND, 8'd0, 56'h0, 16'h0, 8'h00}, 1'b0, NO_RESULT},
        '{'{ACT_SET_STATUS, 8'd23, 56'h0, 16'h0, 8'hFF}, 1'b0, NO_RESULT},
        '{'{ACT_QUERY, 8'd23, 56'h0, 16'h0, 8'h00}, 1'b0, NO_RESULT},
        '{'{ACT_SET_STATUS, 8'd24, 56'h0, 16'h0, 8'h01}, 1'b0, NO_RESULT},
        '{'{ACT_SET_STATUS, 8'd1, 56'h0, 16'h0, 8'h00}, 1'b0, NO_RESULT},
        '{'{ACT_REGISTER, 8'd0, 56'h42, 16'h00FF, 8'h00}, 1'b0, NO_RESULT},
        '{'{ACT_UNREGISTER, 8'd1, 56'h0, 16'h0, 8'h00}, 1'b0, NO_RESULT},
        '{'{ACT_SET_CUR, 8'd23, 56'h0, 16'h0, 8'h00}, 1'b0, NO_RESULT},
        '{'{ACT_SET_CUR, 8'd24, 56'h0, 16'h0, 8'h00}, 1'b0, NO_RESULT},
        '{'{ACT_RSVD_LO, 8'd3, 56'h41, 16'h0001, 8'h01}, 1'b0, NO_RESULT},
        '{'{ACT_RSVD_HI, 8'd255, 56'hFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'hFF}, 1'b0, NO_RESULT}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [2:0]          req_action = '0;
    logic [ID_W-1:0]     req_slot_id = '0;
    logic [NAME_W-1:0]   req_name = '0;
    logic [ENTRY_W-1:0]  req_entry = '0;
    logic [STATUS_W-1:0] req_status = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [ID_W-1:0]     rsp_found;
    logic [STATUS_W-1:0] rsp_status;
    logic [7:0]          rsp_bank;
    logic [NAME_W-1:0]   rsp_name;
    logic [ENTRY_W-1:0]  rsp_entry;
    logic                rsp_in_use;
    logic [7:0]          rsp_count;
    logic [ID_W-1:0]     rsp_current;

    // Mirror of the slot table as the block should hold it.
    logic [STATUS_W-1:0] tbl_status [TABLE_SLOTS];
    logic [NAME_W-1:0]   tbl_name [TABLE_SLOTS];
    logic [ENTRY_W-1:0]  tbl_entry [TABLE_SLOTS];
    logic [7:0]          tbl_used = '0;
    logic [ID_W-1:0]     tbl_current = NONE_SLOT;

    t_slot_result        pending_results [$];
    logic [NAME_W-1:0]   name_pool [POOL_NAMES];

    int sender_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_arm = 0;
    int hold_done = 0;
    int hold_left = 0;
    int fail_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int full_rejects = 0;
    int find_hits = 0;
    logic count_wrapped = 1'b0;

    slot_allocator_name_table #(
        .SLOT_COUNT(TABLE_SLOTS),
        .BANK_BASE (TABLE_BANK)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (req_valid),
        .o_in_ready     (req_ready),
        .i_action       (req_action),
        .i_slot_id      (req_slot_id),
        .i_name_chars   (req_name),
        .i_entry_address(req_entry),
        .i_new_status   (req_status),
        .o_out_valid    (rsp_valid),
        .i_out_ready    (rsp_ready),
        .o_found_slot   (rsp_found),
        .o_slot_status  (rsp_status),
        .o_slot_bank    (rsp_bank),
        .o_slot_name    (rsp_name),
        .o_slot_entry   (rsp_entry),
        .o_slot_in_use  (rsp_in_use),
        .o_in_use_count (rsp_count),
        .o_current_slot (rsp_current)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Only the bytes ahead of the first zero byte belong to a name.
    function automatic logic [NAME_W-1:0] trim_name(logic [NAME_W-1:0] raw);
        int          len;
        logic [63:0] keep;
        len = NAME_W / 8;
        for (int b = NAME_W / 8 - 1; b >= 0; b--) begin
            if (raw[8*b +: 8] == 8'h00) begin
                len = b;
            end
        end
        keep = (64'd1 << (8 * len)) - 64'd1;
        return raw & keep[NAME_W-1:0];
    endfunction

    function automatic t_slot_result predict_slot_result(t_slot_req r);
        t_slot_result      res;
        logic [NAME_W-1:0] nm;
        logic              in_range;
        res = NO_RESULT;
        res.found = NONE_SLOT;
        nm = trim_name(r.name);
        in_range = (r.slot_id < TABLE_SLOTS);
        case (r.action)
            ACT_REGISTER: begin
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (res.found == NONE_SLOT && tbl_status[i] == STATUS_EMPTY) begin
                        res.found = 8'(i);
                    end
                end
                if (res.found == NONE_SLOT) begin
                    full_rejects++;
                end else begin
                    tbl_status[res.found] = STATUS_RUN;
                    tbl_name[res.found] = nm;
                    tbl_entry[res.found] = r.entry;
                    if (tbl_used == 8'hFF) begin
                        count_wrapped = 1'b1;
                    end
                    tbl_used = tbl_used + 8'd1;
                    tbl_current = res.found;
                end
            end
            ACT_UNREGISTER: begin
                if (in_range && tbl_status[r.slot_id] != STATUS_EMPTY) begin
                    tbl_status[r.slot_id] = STATUS_EMPTY;
                    tbl_name[r.slot_id] = '0;
                    tbl_entry[r.slot_id] = '0;
                    if (tbl_used != 8'd0) begin
                        tbl_used = tbl_used - 8'd1;
                    end
                    if (tbl_current == r.slot_id) begin
                        tbl_current = NONE_SLOT;
                    end
                end
            end
            ACT_SET_STATUS: begin
                if (in_range) begin
                    tbl_status[r.slot_id] = r.status;
                end
            end
            ACT_SET_CUR: begin
                if (in_range && tbl_status[r.slot_id] != STATUS_EMPTY) begin
                    tbl_current = r.slot_id;
                end else begin
                    tbl_current = NONE_SLOT;
                end
            end
            ACT_QUERY: begin
                if (in_range) begin
                    res.status = tbl_status[r.slot_id];
                    res.bank = 8'(TABLE_BANK + int'(r.slot_id));
                    res.entry = tbl_entry[r.slot_id];
                    if (tbl_status[r.slot_id] != STATUS_EMPTY) begin
                        res.name = tbl_name[r.slot_id];
                        res.in_use = 1'b1;
                    end
                end
            end
            ACT_FIND: begin
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (res.found == NONE_SLOT && tbl_status[i] != STATUS_EMPTY
                            && tbl_name[i] == nm) begin
                        res.found = 8'(i);
                    end
                end
                if (res.found != NONE_SLOT) begin
                    find_hits++;
                end
            end
            default: begin
            end
        endcase
        res.count = tbl_used;
        res.current = tbl_current;
        return res;
    endfunction

    // Names mostly come from a small pool so that searches hit; half the time
    // the bytes past the terminator carry junk that must be ignored.
    function automatic logic [NAME_W-1:0] pick_name();
        int                k;
        logic [NAME_W-1:0] nm;
        if ($urandom_range(99) < 15) begin
            return 56'({$urandom, $urandom});
        end
        k = $urandom_range(POOL_NAMES - 1);
        nm = name_pool[k];
        if ($urandom_range(1) == 1) begin
            for (int b = k + 1; b < NAME_W / 8; b++) begin
                nm[8*b +: 8] = 8'($urandom);
            end
        end
        return nm;
    endfunction

    function automatic t_slot_req random_request();
        t_slot_req r;
        int        pick;
        if ($urandom_range(99) < 88) begin
            r.slot_id = 8'($urandom_range(TABLE_SLOTS - 1));
        end else begin
            r.slot_id = 8'($urandom_range(255, TABLE_SLOTS));
        end
        r.name = pick_name();
        r.entry = 16'($urandom);
        r.status = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 46) begin
            r.action = ACT_REGISTER;
        end else if (pick < 76) begin
            // Freeing by status write is what lets registers keep succeeding.
            r.action = ACT_SET_STATUS;
            if ($urandom_range(99) < 65) begin
                r.status = STATUS_EMPTY;
            end
        end else if (pick < 81) begin
            r.action = ACT_UNREGISTER;
        end else if (pick < 87) begin
            r.action = ACT_SET_CUR;
        end else if (pick < 93) begin
            r.action = ACT_QUERY;
        end else if (pick < 98) begin
            r.action = ACT_FIND;
        end else begin
            r.action = ($urandom_range(1) == 1) ? ACT_RSVD_HI : ACT_RSVD_LO;
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input t_slot_req r, input logic typed,
                                input t_slot_result typed_res);
        t_slot_result pred;
        while ($urandom_range(99) < sender_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        req_action  <= r.action;
        req_slot_id <= r.slot_id;
        req_name    <= r.name;
        req_entry   <= r.entry;
        req_status  <= r.status;
        @(posedge clk);
        while (!req_ready) begin
            @(posedge clk);
        end
        pred = predict_slot_result(r);
        pending_results.push_back(typed ? typed_res : pred);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endfunction

    // A long hold-off runs to completion once armed; otherwise stall at random.
    always @(negedge clk) begin
        if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm != hold_done) begin
            hold_done <= hold_arm;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk) begin : result_check
        t_slot_result want;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with none expected: found_slot 0x%0h count %0d",
                       rsp_found, rsp_count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("found_slot", 64'(want.found), 64'(rsp_found));
                check_field("slot_status", 64'(want.status), 64'(rsp_status));
                check_field("slot_bank", 64'(want.bank), 64'(rsp_bank));
                check_field("slot_name", 64'(want.name), 64'(rsp_name));
                check_field("slot_entry", 64'(want.entry), 64'(rsp_entry));
                check_field("slot_in_use", 64'(want.in_use), 64'(rsp_in_use));
                check_field("in_use_count", 64'(want.count), 64'(rsp_count));
                check_field("current_slot", 64'(want.current), 64'(rsp_current));
            end
            checked_count++;
        end
    end

    initial begin
        #(5_000_000);
        $display("FAIL slot_allocator_name_table");
        $finish;
    end

    initial begin
        t_slot_req wreq;
        int        idle_by_phase [4];
        int        stall_by_phase [4];
        idle_by_phase = '{0, 62, 0, 28};
        stall_by_phase = '{0, 0, 62, 28};
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            tbl_status[i] = STATUS_EMPTY;
            tbl_name[i] = '0;
            tbl_entry[i] = '0;
        end
        // Pool entry k is a name of exactly k characters.
        for (int k = 0; k < POOL_NAMES; k++) begin
            name_pool[k] = '0;
            for (int b = 0; b < k; b++) begin
                name_pool[k][8*b +: 8] = 8'($urandom_range(255, 1));
            end
        end

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].res);
        end
        wait_for_results();

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = idle_by_phase[ph];
            sink_stall_pct <= stall_by_phase[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The sender keeps offering through the hold-off so the block backs up.
                if (n == 20 && (ph == 0 || ph == 2)) begin
                    hold_arm <= hold_arm + 1;
                end
                if (n == PHASE_ITEMS / 2 && ph == 1) begin
                    wait_for_results();
                end
                send_request(random_request(), 1'b0, NO_RESULT);
            end
            wait_for_results();
        end

        // Keep claiming slots and freeing them by status write, which leaves the
        // count alone, until the in-use count has rolled over.
        sender_idle_pct = 10;
        sink_stall_pct <= 10;
        while (!count_wrapped) begin
            wreq = random_request();
            wreq.action = ACT_SET_STATUS;
            wreq.status = STATUS_EMPTY;
            wreq.slot_id = 8'($urandom_range(TABLE_SLOTS - 1));
            send_request(wreq, 1'b0, NO_RESULT);
            wreq.action = ACT_REGISTER;
            wreq.name = pick_name();
            wreq.entry = 16'($urandom);
            send_request(wreq, 1'b0, NO_RESULT);
        end

        wait_for_results();
        repeat (8) @(negedge clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        $display("Sent %0d requests and checked %0d results, %0d with errors.",
                 sent_count, checked_count, fail_count);
        $display("Registers refused on a full table: %0d, name searches that hit: %0d.",
                 full_rejects, find_hits);
        if (fail_count == 0) begin
            $display("PASS slot_allocator_name_table");
        end else begin
            $display("FAIL slot_allocator_name_table");
        end
        $finish;
    end

endmodule
